// ===== design/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sorted list table
// Field widths, request codes, the entry record, the controller states and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int REQ_W  = 2;
	localparam int KEY_W  = 7;
	localparam int PAY_W  = 3;
	localparam int POS_W  = 5;
	localparam int CNT_W  = 5;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_READ   = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
	} entry_t;

	typedef enum logic [1:0] {
		RD_PREV,
		RD_NEXT,
		RD_POS
	} rd_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INS_RD,
		ST_INS_CMP,
		ST_RM_RD,
		ST_RM_WR,
		ST_FIN
	} slt_state_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_new;
		logic    idx_set_count;
		logic    idx_set_pos;
		logic    idx_dec;
		logic    idx_inc;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             req_ok;
		logic             idx_zero;
		logic             key_ge;
		logic             more;
		logic             out_free;
	} sts_t;

endpackage

// ===== design/sorted_list_table.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table: ordered key table with insert, read and remove
// Keeps up to CAPACITY entries sorted by ascending key, newest first among
// equal keys, and answers every request with one result word.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: key, payload, position
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: read key, payload, count
//
// Requests are handled one at a time through a single-port entry memory.
// Every word passes through the idle state, where it is accepted, the check
// state and the final state that loads the result register; a read or a
// refused request needs no other state. An insert adds a read state and a
// compare state for each entry moved up one slot, and writes the new entry
// in the read state when it lands at the head, else in one more compare
// state after one more read; a remove adds a read and a write state for
// each entry behind the removed one and a last read state. Each moved entry
// costs a memory read and a write.
// Reset clears the controller state, the count and the result valid flag
// only; no clearing pass is needed, as entries beyond the count are never
// read. A new request word is accepted while the previous result still waits
// on m_tready; the block then holds its finished result in the controller's
// final state until the output register frees.
//
module sorted_list_table #(
	parameter int CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [6:0] card_key, [9:7] card_payload, [14:10] position, [15] zero
	input  logic [slt_pkg::IN_DATA_W-1:0]      s_tdata,
	// [1:0] req_type
	input  logic [slt_pkg::REQ_W-1:0]          s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [6:0] read_key, [9:7] read_payload, [14:10] entry_count, [15] zero
	output logic [slt_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] status
	output logic                               m_tuser
);
	import slt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic [KEY_W-1:0] out_key;
	logic [PAY_W-1:0] out_pay;
	logic [CNT_W-1:0] out_count;

	// The controller sequences the memory loop; the datapath owns all other state.
	slt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	slt_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_req     (s_tuser),
		.in_key     (s_tdata[KEY_W-1:0]),
		.in_pay     (s_tdata[KEY_W+PAY_W-1:KEY_W]),
		.in_pos     (s_tdata[KEY_W+PAY_W+POS_W-1:KEY_W+PAY_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_key    (out_key),
		.out_pay    (out_pay),
		.out_count  (out_count)
	);

	// Result word: key in the low bits, then payload, then count, zero padded.
	assign m_tdata = {{(OUT_DATA_W-KEY_W-PAY_W-CNT_W){1'b0}}, out_count, out_pay, out_key};

endmodule

// ===== design/slt_ctrl.sv =====
// ----------------------------------------------------------------------------
// slt_ctrl: request sequencer for the sorted list table
// Steps one request at a time through check, shift loop and result hand-off.
// ----------------------------------------------------------------------------
module slt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          in_ready,
	input  slt_pkg::sts_t sts,
	output slt_pkg::cmd_t cmd
);
	import slt_pkg::*;

	slt_state_t state_q;
	slt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.req_ok) begin
					state_d = ST_FIN;
				end else begin
					unique case (sts.req)
						REQ_INSERT: state_d = ST_INS_RD;
						REQ_REMOVE: state_d = ST_RM_RD;
						default:    state_d = ST_FIN;
					endcase
				end
			end
			ST_INS_RD: begin
				if (sts.idx_zero) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (sts.key_ge) begin
					state_d = ST_INS_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_RM_RD: begin
				if (sts.more) begin
					state_d = ST_RM_WR;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_RM_WR: begin
				state_d = ST_RM_RD;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RD_PREV;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_CHECK: begin
				if (sts.req_ok) begin
					unique case (sts.req)
						REQ_INSERT: cmd.idx_set_count = 1'b1;
						REQ_REMOVE: cmd.idx_set_pos = 1'b1;
						REQ_READ: begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
						end
						default: cmd.rd_en = 1'b0;
					endcase
				end
			end
			ST_INS_RD: begin
				if (sts.idx_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_new = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
				end
			end
			ST_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.key_ge) begin
					cmd.idx_dec = 1'b1;
				end else begin
					cmd.wr_new = 1'b1;
				end
			end
			ST_RM_RD: begin
				if (sts.more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			ST_RM_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_FIN: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/slt_dpath.sv =====
// ----------------------------------------------------------------------------
// slt_dpath: storage and arithmetic for the sorted list table
// Entry memory, request registers, slot index, count and the result register.
// ----------------------------------------------------------------------------
module slt_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slt_pkg::cmd_t                 cmd,
	output slt_pkg::sts_t                 sts,
	input  logic [slt_pkg::REQ_W-1:0]     in_req,
	input  logic [slt_pkg::KEY_W-1:0]     in_key,
	input  logic [slt_pkg::PAY_W-1:0]     in_pay,
	input  logic [slt_pkg::POS_W-1:0]     in_pos,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_status,
	output logic [slt_pkg::KEY_W-1:0]     out_key,
	output logic [slt_pkg::PAY_W-1:0]     out_pay,
	output logic [slt_pkg::CNT_W-1:0]     out_count
);
	import slt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : ((POS_W > CNT_W) ? POS_W : CNT_W);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	entry_t mem [CAPACITY];
	entry_t rd_data_q;

	logic [REQ_W-1:0] req_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [POS_W-1:0] pos_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    count_q;

	logic             out_valid_q;
	logic             out_status_q;
	logic [KEY_W-1:0] out_key_q;
	logic [PAY_W-1:0] out_pay_q;
	logic [CNT_W-1:0] out_count_q;

	logic [XW-1:0] pos_x;
	logic [XW-1:0] count_x;
	logic [XW-1:0] pos_m1;
	logic [CW-1:0] idx_m1;
	logic [CW-1:0] idx_p1;
	logic [AW-1:0] rd_addr;
	logic          pos_ok;
	logic          full;
	logic          req_ok;
	logic [CW-1:0] count_d;
	entry_t        new_entry;

	assign pos_x   = XW'(pos_q);
	assign count_x = XW'(count_q);
	assign pos_m1  = pos_x - XW'(1);
	assign idx_m1  = idx_q - CW'(1);
	assign idx_p1  = idx_q + CW'(1);
	assign pos_ok  = (pos_x != '0) && (pos_x <= count_x);
	assign full    = (count_q == CAP_C);
	assign new_entry = '{key: key_q, pay: pay_q};

	always_comb begin
		case (req_q) inside
			REQ_INSERT:           req_ok = !full;
			REQ_READ, REQ_REMOVE: req_ok = pos_ok;
			default:              req_ok = 1'b0;
		endcase
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_PREV: rd_addr = idx_m1[AW-1:0];
			RD_NEXT: rd_addr = idx_p1[AW-1:0];
			RD_POS:  rd_addr = pos_m1[AW-1:0];
			default: rd_addr = idx_q[AW-1:0];
		endcase
	end

	// Count after the request; it only moves when the result is handed off.
	always_comb begin
		count_d = count_q;
		if (req_ok && (req_q == REQ_INSERT)) begin
			count_d = count_q + CW'(1);
		end else if (req_ok && (req_q == REQ_REMOVE)) begin
			count_d = count_q - CW'(1);
		end
	end

	assign sts.req      = req_q;
	assign sts.req_ok   = req_ok;
	assign sts.idx_zero = (idx_q == '0);
	assign sts.key_ge   = (rd_data_q.key >= key_q);
	assign sts.more     = ({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, count_q};
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[idx_q[AW-1:0]] <= cmd.wr_new ? new_entry : rd_data_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_req;
			key_q <= in_key;
			pay_q <= in_pay;
			pos_q <= in_pos;
		end
		if (cmd.idx_set_count) begin
			idx_q <= count_q;
		end else if (cmd.idx_set_pos) begin
			idx_q <= pos_m1[CW-1:0];
		end else if (cmd.idx_dec) begin
			idx_q <= idx_m1;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_p1;
		end
		if (cmd.finish) begin
			out_status_q <= req_ok ? ST_OK : ST_FAIL;
			out_count_q  <= CNT_W'(count_d);
			if (req_ok && (req_q == REQ_READ)) begin
				out_key_q <= rd_data_q.key;
				out_pay_q <= rd_data_q.pay;
			end else begin
				out_key_q <= '0;
				out_pay_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_key    = out_key_q;
	assign out_pay    = out_pay_q;
	assign out_count  = out_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == ST_FAIL) |-> (out_key_q == '0) && (out_pay_q == '0))
		else $error("failed result carries read data");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken word");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && req_ok && (req_q == REQ_INSERT) |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the count");
`endif

endmodule

// ===== test/tb_sorted_list_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_table: self-checking bench for the sorted list table
// Request words go in on the s_* stream and are mirrored by a shadow copy of
// the table. Each result word on the m_* stream is compared field by field
// with the oldest answer that the shadow copy predicted for it.
// ----------------------------------------------------------------------------
module tb_sorted_list_table;
	import slt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
	// Request code with no operation behind it; the block must refuse it.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	// One predicted result word.
	typedef struct {
		logic             status;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
		logic [CNT_W-1:0] count;
	} table_answer_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// [6:0] card_key, [9:7] card_payload, [14:10] position, [15] zero
	logic [IN_DATA_W-1:0]  s_tdata;
	// [1:0] req_type
	logic [REQ_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [6:0] read_key, [9:7] read_payload, [14:10] entry_count, [15] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	// [0] status
	logic                  m_tuser;

	// Shadow copy of the table contents and its count.
	entry_t        shadow_entries [TABLE_DEPTH];
	int            shadow_count;
	table_answer_t awaited_answers [$];
	int            mismatch_count;
	// Set during the stretch in which neither side idles.
	bit            no_idle;
	// Drift of the random traffic: towards a full table or towards empty.
	bit            filling;

	sorted_list_table #(
		.CAPACITY(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one request to the shadow table and returns the result word
	// that the block should give for it.
	function automatic table_answer_t table_apply(input logic [REQ_W-1:0] code,
			input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay,
			input logic [POS_W-1:0] pos);
		table_answer_t ans;
		int            slot;
		bit            pos_ok;
		ans.status = ST_FAIL;
		ans.key = '0;
		ans.pay = '0;
		pos_ok = (pos >= 1) && (pos <= shadow_count);
		if (code == REQ_INSERT) begin
			if (shadow_count < TABLE_DEPTH) begin
				// New entry goes before the first key that is not smaller,
				// so among equal keys the newest comes first.
				slot = 0;
				while (slot < shadow_count && shadow_entries[slot].key < key)
					slot++;
				for (int i = shadow_count; i > slot; i--)
					shadow_entries[i] = shadow_entries[i - 1];
				shadow_entries[slot].key = key;
				shadow_entries[slot].pay = pay;
				shadow_count++;
				ans.status = ST_OK;
			end
		end else if (code == REQ_READ) begin
			if (pos_ok) begin
				ans.key = shadow_entries[pos - 1].key;
				ans.pay = shadow_entries[pos - 1].pay;
				ans.status = ST_OK;
			end
		end else if (code == REQ_REMOVE) begin
			if (pos_ok) begin
				for (int i = pos - 1; i + 1 < shadow_count; i++)
					shadow_entries[i] = shadow_entries[i + 1];
				shadow_count--;
				ans.status = ST_OK;
			end
		end
		ans.count = shadow_count[CNT_W-1:0];
		return ans;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Sends one request word, with a random gap in front of it now and then.
	// tvalid is left high after the handshake so that a following word goes
	// out back to back; the prediction is made at the moment of acceptance.
	task automatic send_request(input logic [REQ_W-1:0] code, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay, input logic [POS_W-1:0] pos);
		if (!no_idle && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tdata <= {1'b0, pos, pay, key};
		s_tuser <= code;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		awaited_answers.push_back(table_apply(code, key, pay, pos));
	endtask

	task automatic wait_for_answers();
		s_tvalid <= 1'b0;
		while (awaited_answers.size() != 0) @(posedge clk);
	endtask

	// Reads and removes on an empty table must all fail.
	task automatic test_empty_table();
		send_request(REQ_READ, 7'd0, 3'd0, 5'd1);
		send_request(REQ_REMOVE, 7'd127, 3'd7, 5'd1);
	endtask

	// Fills every slot, with repeated keys to check newest-first ordering,
	// then tries one insert too many.
	task automatic test_fill_and_full();
		logic [KEY_W-1:0] keys [TABLE_DEPTH] = '{7'd64, 7'd64, 7'd0, 7'd127, 7'd5, 7'd100,
			7'd64, 7'd33, 7'd90, 7'd1, 7'd126, 7'd42, 7'd42, 7'd77, 7'd12, 7'd120};
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_request(REQ_INSERT, keys[i], 3'(i), 5'(i));
		send_request(REQ_INSERT, 7'd50, 3'd7, 5'd31);
	endtask

	// Reads at both ends and in the middle, then positions of zero and
	// beyond the count, the largest the field can carry among them.
	task automatic test_bad_positions();
		send_request(REQ_READ, 7'd0, 3'd0, 5'd1);
		send_request(REQ_READ, 7'd0, 3'd0, 5'(TABLE_DEPTH));
		send_request(REQ_READ, 7'd0, 3'd0, 5'd8);
		send_request(REQ_READ, 7'd127, 3'd7, 5'd0);
		send_request(REQ_READ, 7'd0, 3'd0, 5'(TABLE_DEPTH + 1));
		send_request(REQ_READ, 7'd0, 3'd0, 5'd31);
		send_request(REQ_REMOVE, 7'd0, 3'd0, 5'd0);
		send_request(REQ_REMOVE, 7'd0, 3'd0, 5'd20);
	endtask

	// Removing the head must succeed like any other position; also the
	// tail, and a word with the unused request code.
	task automatic test_remove_ends();
		send_request(REQ_REMOVE, 7'd0, 3'd0, 5'd1);
		send_request(REQ_REMOVE, 7'd0, 3'd0, 5'(shadow_count));
		send_request(REQ_READ, 7'd0, 3'd0, 5'd1);
		send_request(REQ_UNUSED, 7'd127, 3'd7, 5'd31);
	endtask

	// Mostly well-formed traffic that sweeps the count between empty and
	// full, with a share of refused words mixed in.
	task automatic test_random_traffic(input int n);
		logic [REQ_W-1:0] code;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
		logic [POS_W-1:0] pos;
		int               pick;
		for (int i = 0; i < n; i++) begin
			if (shadow_count == TABLE_DEPTH)
				filling = 1'b0;
			else if (shadow_count == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 99) < 3)
				filling = ~filling;
			// Keys partly copy stored ones, so that duplicates are common.
			if (shadow_count > 0 && $urandom_range(0, 99) < 30)
				key = shadow_entries[$urandom_range(0, shadow_count - 1)].key;
			else
				key = KEY_W'($urandom_range(0, 127));
			pay = PAY_W'($urandom_range(0, 7));
			pos = (shadow_count > 0) ? POS_W'($urandom_range(1, shadow_count)) : 5'd1;
			code = $urandom_range(0, 1) ? REQ_READ : REQ_REMOVE;
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				case ($urandom_range(0, 3))
					0: begin
						code = REQ_UNUSED;
						pos = POS_W'($urandom_range(0, 31));
					end
					1: pos = '0;
					2: pos = POS_W'($urandom_range(shadow_count + 1, 31));
					default: code = REQ_INSERT;
				endcase
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < (filling ? 60 : 15)) begin
					code = REQ_INSERT;
					pos = POS_W'($urandom_range(0, 31));
				end else if (pick < (filling ? 80 : 35)) begin
					code = REQ_READ;
				end else begin
					code = REQ_REMOVE;
				end
			end
			send_request(code, key, pay, pos);
		end
	endtask

	// Random traffic with both sides streaming at full rate.
	task automatic test_back_to_back(input int n);
		no_idle = 1'b1;
		test_random_traffic(n);
		no_idle = 1'b0;
	endtask

	// The sender holds off until every result is in, then carries on.
	task automatic test_drain_pause();
		test_random_traffic(30);
		wait_for_answers();
		test_random_traffic(30);
	endtask

	// Result side: checks each accepted word, then decides whether to stall.
	initial begin
		table_answer_t want;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (awaited_answers.size() == 0) begin
					$display("%0t ns: result word with none expected, actual %h / %b",
						$time, m_tdata, m_tuser);
					mismatch_count++;
				end else begin
					want = awaited_answers.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("read_key", want.key, m_tdata[KEY_W-1:0]);
					check_field("read_payload", want.pay, m_tdata[KEY_W+PAY_W-1:KEY_W]);
					check_field("entry_count", want.count,
						m_tdata[KEY_W+PAY_W+CNT_W-1:KEY_W+PAY_W]);
				end
			end
			m_tready <= no_idle || ($urandom_range(0, 99) >= 10);
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long.
	initial begin
		int stalled_cycles;
		stalled_cycles = 0;
		wait (arst_n === 1'b1);
		while (stalled_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
		end
		$display("sorted_list_table test failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		shadow_count = 0;
		mismatch_count = 0;
		no_idle = 1'b0;
		filling = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_and_full();
		test_bad_positions();
		test_remove_ends();
		test_random_traffic(300);
		test_back_to_back(150);
		test_drain_pause();
		test_random_traffic(190);

		// Let the last results arrive, then watch for stray words.
		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_answers.size() == 0)
			$display("sorted_list_table test passed");
		else
			$display("sorted_list_table test failed");
		$finish;
	end

endmodule
